/* rtl/core/h264_nal_unit_splitter_macros.svh */
// assertion macros used by the output back of the nal unit splitter
`ifndef H264_NAL_UNIT_SPLITTER_MACROS_SVH
`define H264_NAL_UNIT_SPLITTER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define H264NAL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define H264NAL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/h264nal_pkg.sv */
// shared types and constants of the nal unit splitter
`default_nettype none

package h264nal_pkg;

    localparam int MAX_LENGTH_FIELD_BYTES_DEF = 4;
    localparam int QUEUE_DEPTH_DEF            = 4;
    localparam int HOLD_BYTES                 = 4;
    localparam logic [2:0] RESULT_CAP         = 3'd4;

    // configuration register indexes
    localparam logic CFG_LENGTH_PREFIXED_MODE = 1'b0;
    localparam logic CFG_LENGTH_FIELD_BYTES   = 1'b1;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NO_START  = 3'd1;
    localparam logic [2:0] ERR_TRUNCATED = 3'd2;
    localparam logic [2:0] ERR_FORBIDDEN = 3'd3;
    localparam logic [2:0] ERR_EMPTY     = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SEEK,
        PH_SC_HEAD,
        PH_SC_BODY,
        PH_LEN_HOLD,
        PH_LEN_HEAD,
        PH_LEN_BODY
    } phase_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       unit_first;
        logic       unit_final;
        logic [4:0] unit_type;
        logic [1:0] reference_bits;
        logic [2:0] error_code;
        logic       buffer_done;
    } result_t;

    // all results caused by one input byte
    typedef struct packed {
        result_t [3:0] res;
        logic [2:0]    n;
    } group_t;

endpackage

`default_nettype wire

/* rtl/core/h264nal_in_if.sv */
// input byte channel of the nal unit splitter
`default_nettype none

interface h264nal_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       buffer_last;

    modport source (output valid, output stream_byte, output buffer_last, input ready);
    modport sink (input valid, input stream_byte, input buffer_last, output ready);
endinterface

`default_nettype wire

/* rtl/core/h264nal_out_if.sv */
// result channel of the nal unit splitter
`default_nettype none

interface h264nal_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       unit_first;
    logic       unit_final;
    logic [4:0] unit_type;
    logic [1:0] reference_bits;
    logic [2:0] error_code;
    logic       buffer_done;

    modport source (
        output valid, output payload_byte, output unit_first, output unit_final,
        output unit_type, output reference_bits, output error_code, output buffer_done,
        input ready
    );
    modport sink (
        input valid, input payload_byte, input unit_first, input unit_final,
        input unit_type, input reference_bits, input error_code, input buffer_done,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/core/h264nal_queue.sv */
// result group queue between the parser front and the output back
`default_nettype none

module h264nal_queue
    import h264nal_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire group_t push_data,
    output logic        full,
    input  wire logic   pop,
    output group_t      head,
    output logic        head_valid
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    group_t          slots [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    assign head       = slots[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CW'(DEPTH));

endmodule

`default_nettype wire

/* rtl/core/h264nal_front.sv */
// parser front: takes bytes, tracks framing state, builds result groups
`default_nettype none

module h264nal_front
    import h264nal_pkg::*;
#(
    parameter int MAX_LENGTH_FIELD_BYTES = MAX_LENGTH_FIELD_BYTES_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [2:0] cfg_data,
    h264nal_in_if.sink      in_ch,
    output logic            push,
    output group_t          push_data,
    input  wire logic       queue_full
);

    localparam int LEN_W = 8 * MAX_LENGTH_FIELD_BYTES;

    typedef logic [3:0][7:0] pend_t;

    typedef struct packed {
        phase_t           phase;
        logic [2:0][7:0]  la;
        logic [1:0]       la_cnt;
        logic [LEN_W-1:0] left;
        logic [7:0]       hdr;
        logic             errl;
    } fstate_t;

    logic       mode_reg;
    logic [2:0] lfb_reg;
    fstate_t    state_reg, state_next;
    group_t     step_group;
    logic       accept;

    function automatic result_t mk_result(input logic [7:0] b, input logic first,
                                          input logic fin, input logic [7:0] hdr,
                                          input logic [2:0] code);
        result_t r;
        r.payload_byte   = b;
        r.unit_first     = first;
        r.unit_final     = fin;
        r.unit_type      = hdr[4:0];
        r.reference_bits = hdr[6:5];
        r.error_code     = code;
        r.buffer_done    = 1'b0;
        return r;
    endfunction

    function automatic void push_result(inout group_t g, input result_t r);
        if (g.n < RESULT_CAP)
        begin
            g.res[g.n[1:0]] = r;
            g.n = g.n + 3'd1;
        end
    endfunction

    function automatic void raise_error(inout fstate_t st, inout group_t g,
                                        input logic [2:0] code);
        push_result(g, mk_result(8'h00, 1'b0, 1'b0, 8'h00, code));
        st.errl = 1'b1;
    endfunction

    // lookahead takes pend[from] up to pend[to-1], three bytes at most
    function automatic void keep(inout fstate_t st, input pend_t pend,
                                 input logic [2:0] from, input logic [2:0] to);
        st.la     = '0;
        st.la_cnt = '0;
        for (int j = 0; j < 3; j++)
        begin
            if (int'(from) + j < int'(to))
            begin
                st.la[j]  = pend[2'(int'(from) + j)];
                st.la_cnt = st.la_cnt + 2'd1;
            end
        end
    endfunction

    function automatic logic unit_byte(inout fstate_t st, inout group_t g,
                                       input logic [7:0] b, input logic fin);
        logic ok;
        logic first;
        ok    = 1'b1;
        first = 1'b0;
        if (st.phase inside {PH_SC_HEAD, PH_LEN_HEAD})
        begin
            if (b[7])
            begin
                raise_error(st, g, ERR_FORBIDDEN);
                ok = 1'b0;
            end
            else
            begin
                st.hdr = b;
                if (st.phase == PH_SC_HEAD)
                begin
                    st.phase = PH_SC_BODY;
                end
                else
                begin
                    st.phase = PH_LEN_BODY;
                end
                first = 1'b1;
            end
        end
        if (ok)
        begin
            push_result(g, mk_result(b, first, fin, st.hdr, ERR_NONE));
        end
        return ok;
    endfunction

    function automatic void sc_unit(inout fstate_t st, inout group_t g, input pend_t pend,
                                    input logic [2:0] np, input logic last);
        logic       stop;
        logic [1:0] top;
        stop = 1'b0;
        top  = 2'(np - 3'd1);
        if (last)
        begin
            // buffer end flushes everything held
            for (int i = 0; i < HOLD_BYTES; i++)
            begin
                if (!stop && i < int'(np))
                begin
                    if (!unit_byte(st, g, pend[i], (i == int'(np) - 1)))
                    begin
                        stop = 1'b1;
                    end
                end
            end
            keep(st, pend, 3'd0, 3'd0);
        end
        else if (np >= 3'd3 && pend[top - 2'd2] == 8'h00 && pend[top - 2'd1] == 8'h00
                 && pend[top] == 8'h01)
        begin
            keep(st, pend, 3'd0, 3'd0);
            if (np == 3'd4)
            begin
                if (unit_byte(st, g, pend[0], 1'b1))
                begin
                    st.phase = PH_SC_HEAD;
                end
            end
            else
            begin
                // start code right after a start code
                raise_error(st, g, ERR_EMPTY);
            end
        end
        else if (np == 3'd4)
        begin
            if (unit_byte(st, g, pend[0], 1'b0))
            begin
                keep(st, pend, 3'd1, 3'd4);
            end
        end
        else
        begin
            keep(st, pend, 3'd0, np);
        end
    endfunction

    function automatic void len_hold(inout fstate_t st, inout group_t g, input pend_t pend,
                                     input logic [2:0] np, input logic last,
                                     input logic [2:0] nb);
        logic [LEN_W-1:0] len;
        logic             stop;
        logic             fin;
        len  = '0;
        stop = 1'b0;
        fin  = 1'b0;
        if (np < 3'(HOLD_BYTES))
        begin
            if (!last)
            begin
                keep(st, pend, 3'd0, np);
            end
        end
        else
        begin
            for (int i = 0; i < MAX_LENGTH_FIELD_BYTES; i++)
            begin
                if (i < int'(nb))
                begin
                    len = (len << 8) | LEN_W'(pend[i]);
                end
            end
            keep(st, pend, 3'd0, 3'd0);
            if (len == '0)
            begin
                raise_error(st, g, ERR_EMPTY);
            end
            else
            begin
                st.left  = len - LEN_W'(3'(HOLD_BYTES) - nb);
                st.phase = PH_LEN_HEAD;
                // unit bytes that share the hold window with the length field
                for (int i = 0; i < HOLD_BYTES; i++)
                begin
                    if (!stop && i >= int'(nb))
                    begin
                        fin = (len == LEN_W'(i + 1) - LEN_W'(nb));
                        if (!unit_byte(st, g, pend[i], fin))
                        begin
                            stop = 1'b1;
                        end
                        else if (fin)
                        begin
                            st.phase = PH_LEN_HOLD;
                            if (!last)
                            begin
                                keep(st, pend, 3'(i + 1), 3'd4);
                            end
                            stop = 1'b1;
                        end
                    end
                end
                if (!stop && last)
                begin
                    raise_error(st, g, ERR_TRUNCATED);
                end
            end
        end
    endfunction

    // next framing state and the result group of the byte on the input
    always_comb
    begin : step_logic
        fstate_t    st;
        group_t     g;
        pend_t      pend;
        pend_t      one;
        logic [1:0] k;
        logic [2:0] np;
        logic [2:0] nb;
        logic       last;
        logic       fin;
        st   = state_reg;
        g    = '0;
        one  = '0;
        last = in_ch.buffer_last;
        fin  = 1'b0;
        if (lfb_reg == 3'd0)
        begin
            nb = 3'd1;
        end
        else if (lfb_reg > 3'(MAX_LENGTH_FIELD_BYTES))
        begin
            nb = 3'(MAX_LENGTH_FIELD_BYTES);
        end
        else
        begin
            nb = lfb_reg;
        end
        if (st.phase == PH_IDLE)
        begin
            st.phase  = mode_reg ? PH_LEN_HOLD : PH_SEEK;
            st.la     = '0;
            st.la_cnt = '0;
        end
        k       = st.la_cnt;
        pend    = {8'h00, st.la};
        pend[k] = in_ch.stream_byte;
        np      = {1'b0, k} + 3'd1;
        if (!state_reg.errl)
        begin
            case (st.phase)
                PH_SEEK:
                begin
                    if (k == 2'd3 && pend[0] == 8'h00 && pend[1] == 8'h00
                        && pend[2] == 8'h01)
                    begin
                        st.phase = PH_SC_HEAD;
                        one[0]   = in_ch.stream_byte;
                        sc_unit(st, g, one, 3'd1, last);
                    end
                    else if (last)
                    begin
                        if (np == 3'd4)
                        begin
                            raise_error(st, g, ERR_NO_START);
                        end
                    end
                    else if (np == 3'd4)
                    begin
                        keep(st, pend, 3'd1, 3'd4);
                    end
                    else
                    begin
                        keep(st, pend, 3'd0, np);
                    end
                end
                PH_SC_HEAD, PH_SC_BODY:
                begin
                    sc_unit(st, g, pend, np, last);
                end
                PH_LEN_HOLD:
                begin
                    len_hold(st, g, pend, np, last, nb);
                end
                default:
                begin
                    if (st.left != '0)
                    begin
                        st.left = st.left - LEN_W'(1);
                    end
                    fin = (st.left == '0);
                    if (unit_byte(st, g, in_ch.stream_byte, fin))
                    begin
                        if (fin)
                        begin
                            st.phase = PH_LEN_HOLD;
                            keep(st, pend, 3'd0, 3'd0);
                        end
                        else if (last)
                        begin
                            raise_error(st, g, ERR_TRUNCATED);
                        end
                    end
                end
            endcase
        end
        else
        begin
            st = state_reg;
        end
        if (last)
        begin
            if (g.n == 3'd0)
            begin
                push_result(g, mk_result(8'h00, 1'b0, 1'b0, 8'h00, ERR_NONE));
            end
            g.res[2'(g.n - 3'd1)].buffer_done = 1'b1;
            st = '0;
        end
        state_next = st;
        step_group = g;
    end

    always_comb
    begin
        in_ch.ready = !queue_full;
        accept      = in_ch.valid && !queue_full;
        push        = accept && (step_group.n != 3'd0);
        push_data   = step_group;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            mode_reg  <= 1'b0;
            lfb_reg   <= 3'd4;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LENGTH_PREFIXED_MODE: mode_reg <= cfg_data[0];
                    CFG_LENGTH_FIELD_BYTES:   lfb_reg  <= cfg_data;
                    default:                  ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/h264nal_back.sv */
// output back: walks each queued group into the output register, one result per cycle while out_ch is ready
`default_nettype none
`include "h264_nal_unit_splitter_macros.svh"

module h264nal_back
    import h264nal_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire group_t head,
    input  wire logic   head_valid,
    output logic        pop,
    h264nal_out_if.source out_ch
);

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    result_t    out_data_reg;
    logic       load;
    logic       last_of_group;

    always_comb
    begin
        load           = head_valid && (!out_valid_reg || out_ch.ready);
        last_of_group  = (3'(idx_reg) == head.n - 3'd1);
        pop            = load && last_of_group;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            idx_next       = last_of_group ? 2'd0 : idx_reg + 2'd1;
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= head.res[idx_reg];
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.payload_byte   = out_data_reg.payload_byte;
    assign out_ch.unit_first     = out_data_reg.unit_first;
    assign out_ch.unit_final     = out_data_reg.unit_final;
    assign out_ch.unit_type      = out_data_reg.unit_type;
    assign out_ch.reference_bits = out_data_reg.reference_bits;
    assign out_ch.error_code     = out_data_reg.error_code;
    assign out_ch.buffer_done    = out_data_reg.buffer_done;

    `H264NAL_ASSERT_IMP(a_group_size, head_valid, head.n != 3'd0 && head.n <= RESULT_CAP, "queued group has no results or too many")
    `H264NAL_ASSERT_IMP(a_index_in_group, head_valid, 3'(idx_reg) < head.n, "result index beyond its group")
    `H264NAL_ASSERT_IMP(a_done_on_group_end, head_valid && !last_of_group, !head.res[idx_reg].buffer_done, "buffer done before the group end")
    `H264NAL_ASSERT_NXT(a_index_steps, load && !last_of_group, idx_reg == $past(idx_reg) + 2'd1, "result index did not advance")

endmodule

`default_nettype wire

/* rtl/core/h264_nal_unit_splitter.sv */
// H.264 NAL unit splitter: in_ch takes one buffer byte per transfer, buffer_last on
// the final byte; out_ch gives unit bytes with first/final marks, unit type,
// reference bits, an error code and buffer_done on the last result of a buffer.
// cfg_we/cfg_index/cfg_data write length_prefixed_mode (index 0) and
// length_field_bytes (index 1); write them only between buffers.
// throughput: one byte per cycle on in_ch; each byte yields zero to four results
// and out_ch drains one result per cycle while ready, so bursts of multi-result
// bytes are absorbed by a queue of QUEUE_DEPTH result groups between the parser
// and the output register; in_ch.ready drops while that queue is full.
// the results of a byte enter the queue at its transfer and are then registered into
// the out_ch output register one at a time.
// in start-code mode a unit byte leaves only once three newer bytes have arrived
// or the buffer ends, since those bytes may begin the next start code.
// reset clears the framing state, empties the queue and sets mode 0 with four
// length bytes; every buffer end also returns the framing state to idle.
// a stalled out_ch holds its result; the parser keeps accepting until the queue fills.
`default_nettype none

module h264_nal_unit_splitter
    import h264nal_pkg::*;
#(
    parameter int MAX_LENGTH_FIELD_BYTES = MAX_LENGTH_FIELD_BYTES_DEF,
    parameter int QUEUE_DEPTH            = QUEUE_DEPTH_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [2:0] cfg_data,
    h264nal_in_if.sink      in_ch,
    h264nal_out_if.source   out_ch
);

    logic   push;
    group_t push_data;
    logic   queue_full;
    logic   pop;
    group_t head;
    logic   head_valid;

    h264nal_front #(
        .MAX_LENGTH_FIELD_BYTES(MAX_LENGTH_FIELD_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .push      (push),
        .push_data (push_data),
        .queue_full(queue_full)
    );

    h264nal_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .head      (head),
        .head_valid(head_valid)
    );

    h264nal_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .head_valid(head_valid),
        .pop       (pop),
        .out_ch    (out_ch)
    );

endmodule

`default_nettype wire

/* test/h264_nal_unit_splitter_tb.sv */
// self-checking testbench of the nal unit splitter: directed and random buffers in both modes
`timescale 1ns / 100ps

module h264_nal_unit_splitter_tb;
    import h264nal_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_BYTES  = 9;
    localparam int PHASE_COUNT  = 8;

    localparam logic [7:0] SC_ZERO = 8'h00;
    localparam logic [7:0] SC_ONE  = 8'h01;

    localparam logic       PHASE_MODE [PHASE_COUNT] =
        '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
    localparam logic [2:0] PHASE_LEN_BYTES [PHASE_COUNT] =
        '{3'd4, 3'd1, 3'd1, 3'd2, 3'd3, 3'd0, 3'd7, 3'd5};

    typedef struct packed {
        logic [7:0] data;
        logic       is_last;
    } stream_item_t;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic       cfg_index = CFG_LENGTH_PREFIXED_MODE;
    logic [2:0] cfg_data  = 3'd0;
    logic       in_valid  = 1'b0;
    logic [7:0] in_byte   = 8'h00;
    logic       in_last   = 1'b0;
    logic       out_ready = 1'b0;

    h264nal_in_if  in_ch();
    h264nal_out_if out_ch();

    assign in_ch.valid       = in_valid;
    assign in_ch.stream_byte = in_byte;
    assign in_ch.buffer_last = in_last;
    assign out_ch.ready      = out_ready;

    h264_nal_unit_splitter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // predictor copy of the registers and the framing state
    logic        cfg_len_mode;
    logic [2:0]  cfg_len_bytes;
    phase_t      phase;
    logic [23:0] la_bytes;
    int          la_count;
    logic [31:0] len_accum;
    int          len_count;
    logic [31:0] unit_left;
    logic [7:0]  header;
    logic        fault_seen;

    result_t      byte_results[$];
    result_t      expected_results[$];
    stream_item_t stream_q[$];
    logic [7:0]   buf_bytes[$];
    stream_item_t next_item;

    bit in_taken      = 1'b0;
    int send_idle_pct = 34;
    int recv_idle_pct = 55;
    int idle_cycles   = 0;
    int errors        = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_framing();
        phase      = PH_IDLE;
        la_bytes   = '0;
        la_count   = 0;
        len_accum  = '0;
        len_count  = 0;
        unit_left  = '0;
        header     = '0;
        fault_seen = 1'b0;
    endfunction

    function automatic int field_size();
        int nb;
        nb = int'(cfg_len_bytes);
        if (nb < 1)
            nb = 1;
        if (nb > MAX_LENGTH_FIELD_BYTES_DEF)
            nb = MAX_LENGTH_FIELD_BYTES_DEF;
        return nb;
    endfunction

    function automatic void add_result(input logic [7:0] pay, input logic first,
                                       input logic fin, input logic [7:0] hdr,
                                       input logic [2:0] err);
        result_t r;
        if (byte_results.size() >= RESULT_CAP)
            return;
        r.payload_byte   = pay;
        r.unit_first     = first;
        r.unit_final     = fin;
        r.unit_type      = hdr[4:0];
        r.reference_bits = hdr[6:5];
        r.error_code     = err;
        r.buffer_done    = 1'b0;
        byte_results.insert(byte_results.size(), r);
    endfunction

    function automatic void add_buffer_byte(input logic [7:0] b);
        buf_bytes.insert(buf_bytes.size(), b);
    endfunction

    function automatic void raise_fault(input logic [2:0] code);
        add_result(8'h00, 1'b0, 1'b0, 8'h00, code);
        fault_seen = 1'b1;
    endfunction

    // keep up to three of pend[lo..hi-1] as lookahead, oldest in the low byte
    function automatic void hold_bytes(input logic [7:0] pend [4], input int lo, input int hi);
        int i;
        la_bytes = '0;
        la_count = 0;
        for (i = lo; i < hi && la_count < 3; i++)
        begin
            la_bytes |= 24'(pend[i]) << (8 * la_count);
            la_count++;
        end
    endfunction

    // returns 0 when the header byte carries the forbidden bit
    function automatic bit emit_unit_byte(input logic [7:0] b, input logic fin);
        logic first;
        first = 1'b0;
        if (phase == PH_SC_HEAD || phase == PH_LEN_HEAD)
        begin
            if (b[7])
            begin
                raise_fault(ERR_FORBIDDEN);
                return 1'b0;
            end
            header = b;
            phase  = phase_t'(phase + 3'd1);
            first  = 1'b1;
        end
        add_result(b, first, fin, header, ERR_NONE);
        return 1'b1;
    endfunction

    function automatic void start_code_unit(input logic [7:0] pend [4], input int np,
                                            input bit is_last);
        int i;
        if (is_last)
        begin
            for (i = 0; i < np; i++)
                if (!emit_unit_byte(pend[i], i == np - 1))
                    return;
            hold_bytes(pend, 0, 0);
            return;
        end
        if (np >= 3 && pend[np - 3] == SC_ZERO && pend[np - 2] == SC_ZERO && pend[np - 1] == SC_ONE)
        begin
            hold_bytes(pend, 0, 0);
            // a start code right after a start code leaves an empty unit
            if (np == 4)
            begin
                if (emit_unit_byte(pend[0], 1'b1))
                    phase = PH_SC_HEAD;
            end
            else
                raise_fault(ERR_EMPTY);
            return;
        end
        if (np == 4)
        begin
            if (emit_unit_byte(pend[0], 1'b0))
                hold_bytes(pend, 1, 4);
        end
        else
            hold_bytes(pend, 0, np);
    endfunction

    function automatic void length_field(input logic [7:0] pend [4], input int np,
                                         input bit is_last);
        int          nb;
        int          i;
        logic [31:0] len;
        logic        fin;
        // a short tail is dropped
        if (np < HOLD_BYTES)
        begin
            if (!is_last)
                hold_bytes(pend, 0, np);
            return;
        end
        nb        = field_size();
        len_count = nb;
        len       = '0;
        for (i = 0; i < nb; i++)
            len = (len << 8) | 32'(pend[i]);
        len_accum = len;
        hold_bytes(pend, 0, 0);
        if (len == 0)
        begin
            raise_fault(ERR_EMPTY);
            return;
        end
        unit_left = len;
        phase     = PH_LEN_HEAD;
        for (i = nb; i < HOLD_BYTES; i++)
        begin
            unit_left--;
            fin = (unit_left == 0);
            if (!emit_unit_byte(pend[i], fin))
                return;
            if (fin)
            begin
                phase = PH_LEN_HOLD;
                if (!is_last)
                    hold_bytes(pend, i + 1, HOLD_BYTES);
                return;
            end
        end
        if (is_last)
            raise_fault(ERR_TRUNCATED);
    endfunction

    function automatic void split_byte(input logic [7:0] b, input bit is_last);
        logic [7:0] pend [4];
        int         k;
        int         np;
        int         i;
        logic       fin;
        pend = '{default: 8'h00};
        if (phase == PH_IDLE)
        begin
            phase = cfg_len_mode ? PH_LEN_HOLD : PH_SEEK;
            hold_bytes(pend, 0, 0);
        end
        k = (la_count > 3) ? 3 : la_count;
        for (i = 0; i < k; i++)
            pend[i] = la_bytes[8 * i +: 8];
        pend[k] = b;
        np      = k + 1;
        case (phase)
            PH_SEEK:
            begin
                if (k == 3 && pend[0] == SC_ZERO && pend[1] == SC_ZERO && pend[2] == SC_ONE)
                begin
                    phase   = PH_SC_HEAD;
                    pend[0] = b;
                    start_code_unit(pend, 1, is_last);
                end
                else if (is_last)
                begin
                    if (np == 4)
                        raise_fault(ERR_NO_START);
                end
                else if (np == 4)
                    hold_bytes(pend, 1, 4);
                else
                    hold_bytes(pend, 0, np);
            end
            PH_SC_HEAD, PH_SC_BODY:
                start_code_unit(pend, np, is_last);
            PH_LEN_HOLD:
                length_field(pend, np, is_last);
            default:
            begin
                if (unit_left > 0)
                    unit_left--;
                fin = (unit_left == 0);
                if (emit_unit_byte(b, fin))
                begin
                    if (fin)
                    begin
                        phase = PH_LEN_HOLD;
                        hold_bytes(pend, 0, 0);
                    end
                    else if (is_last)
                        raise_fault(ERR_TRUNCATED);
                end
            end
        endcase
    endfunction

    function automatic void predict_transfer(input logic [7:0] b, input bit is_last);
        byte_results.delete();
        if (!fault_seen)
            split_byte(b, is_last);
        if (is_last)
        begin
            // status result when the final byte gives nothing else
            if (byte_results.size() == 0)
                add_result(8'h00, 1'b0, 1'b0, 8'h00, ERR_NONE);
            byte_results[byte_results.size() - 1].buffer_done = 1'b1;
            clear_framing();
        end
        foreach (byte_results[i])
            expected_results.insert(expected_results.size(), byte_results[i]);
    endfunction

    function automatic string format_result(input result_t r);
        return $sformatf("byte %h first %b final %b type %0d ref %0d err %0d done %b",
                         r.payload_byte, r.unit_first, r.unit_final, r.unit_type,
                         r.reference_bits, r.error_code, r.buffer_done);
    endfunction

    task automatic check_result(input result_t got);
        result_t want;
        if (expected_results.size() == 0)
        begin
            $display("%0t: expected none actual %s", $time, format_result(got));
            errors++;
            return;
        end
        want = expected_results.pop_front();
        if (got !== want)
        begin
            $display("%0t: expected %s actual %s", $time, format_result(want),
                     format_result(got));
            errors++;
        end
    endtask

    task automatic commit_buffer();
        stream_item_t item;
        foreach (buf_bytes[i])
        begin
            item.data    = buf_bytes[i];
            item.is_last = (i == buf_bytes.size() - 1);
            stream_q.insert(stream_q.size(), item);
        end
        buf_bytes.delete();
    endtask

    task automatic add_noise_buffer(input int lo, input int hi);
        int n;
        int j;
        n = $urandom_range(lo, hi);
        for (j = 0; j < n; j++)
            add_buffer_byte(($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom));
        commit_buffer();
    endtask

    task automatic add_start_code_buffer();
        int         kind;
        int         units;
        int         flaw_unit;
        int         flaw;
        int         body;
        int         u;
        int         j;
        logic [7:0] hdr;
        kind = $urandom_range(0, 9);
        if (kind >= 8)
        begin
            if (kind == 8)
                add_noise_buffer(4, 9);
            else
                add_noise_buffer(1, 3);
            return;
        end
        units     = $urandom_range(1, 3);
        flaw_unit = (kind >= 6) ? $urandom_range(0, units - 1) : -1;
        flaw      = $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            add_buffer_byte(8'($urandom_range(2, 255)));
        for (u = 0; u < units; u++)
        begin
            if ($urandom_range(0, 1) == 1)
                add_buffer_byte(SC_ZERO);
            add_buffer_byte(SC_ZERO);
            add_buffer_byte(SC_ZERO);
            add_buffer_byte(SC_ONE);
            if (u == flaw_unit && flaw == 1)
            begin
                add_buffer_byte(SC_ZERO);
                add_buffer_byte(SC_ZERO);
                add_buffer_byte(SC_ONE);
            end
            hdr = {1'b0, 7'($urandom)};
            if (u == flaw_unit && flaw == 0)
                hdr[7] = 1'b1;
            add_buffer_byte(hdr);
            body = $urandom_range(0, 6);
            for (j = 0; j < body; j++)
                add_buffer_byte(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
        end
        // trailing start code with nothing after it
        if (flaw_unit >= 0 && flaw == 2)
        begin
            add_buffer_byte(SC_ZERO);
            add_buffer_byte(SC_ZERO);
            add_buffer_byte(SC_ONE);
        end
        commit_buffer();
    endtask

    task automatic add_length_buffer();
        int         kind;
        int         nb;
        int         units;
        int         flaw_unit;
        int         flaw;
        int         len;
        int         u;
        int         j;
        logic [7:0] hdr;
        kind = $urandom_range(0, 9);
        if (kind >= 8)
        begin
            if (kind == 8)
                add_noise_buffer(4, 9);
            else
                add_noise_buffer(1, 3);
            return;
        end
        nb        = field_size();
        units     = $urandom_range(1, 3);
        flaw      = $urandom_range(0, 3);
        flaw_unit = -1;
        if (kind >= 6)
            flaw_unit = (flaw == 2) ? units - 1 : $urandom_range(0, units - 1);
        for (u = 0; u < units; u++)
        begin
            len = $urandom_range(1, 7);
            if (u == flaw_unit && flaw == 1)
                len = 0;
            for (j = nb - 1; j >= 0; j--)
                add_buffer_byte(8'(len >> (8 * j)));
            if (len == 0)
                continue;
            hdr = {1'b0, 7'($urandom)};
            if (u == flaw_unit && flaw == 0)
                hdr[7] = 1'b1;
            add_buffer_byte(hdr);
            for (j = 1; j < len; j++)
                add_buffer_byte(8'($urandom));
            if (u == flaw_unit && flaw == 2)
                repeat ($urandom_range(1, len))
                    void'(buf_bytes.pop_back());
        end
        if (flaw_unit >= 0 && flaw == 3)
            repeat ($urandom_range(1, 3))
                add_buffer_byte(8'($urandom));
        commit_buffer();
    endtask

    task automatic write_config(input logic mode, input logic [2:0] len_bytes);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LENGTH_PREFIXED_MODE;
        cfg_data  <= {2'($urandom), mode};
        @(negedge clk);
        cfg_index <= CFG_LENGTH_FIELD_BYTES;
        cfg_data  <= len_bytes;
        @(negedge clk);
        cfg_we        <= 1'b0;
        cfg_len_mode  = mode;
        cfg_len_bytes = len_bytes;
    endtask

    task automatic wait_drained();
        while (stream_q.size() != 0 || in_valid || expected_results.size() != 0)
        begin
            @(posedge clk);
            #1;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        #1;
    endtask

    // driver: a new byte goes out once the previous one made its transfer
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            in_taken = 1'b0;
            if (stream_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_item = stream_q.pop_front();
                in_byte  <= next_item.data;
                in_last  <= next_item.is_last;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
        out_ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // monitor: predict on input transfers, check output transfers
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ch.ready)
            begin
                predict_transfer(in_byte, in_last);
                in_taken = 1'b1;
            end
            if (out_ch.valid && out_ready)
                check_result({out_ch.payload_byte, out_ch.unit_first, out_ch.unit_final,
                              out_ch.unit_type, out_ch.reference_bits, out_ch.error_code,
                              out_ch.buffer_done});
            if ((in_valid && in_ch.ready) || (out_ch.valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        cfg_len_mode  = 1'b0;
        cfg_len_bytes = 3'd4;
        clear_framing();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // start codes at reset settings: good unit then forbidden header,
        // no start code, short buffer
        buf_bytes = {8'h00, 8'h00, 8'h01, 8'h7f, 8'h00, 8'h00, 8'h01, 8'he5};
        commit_buffer();
        buf_bytes = {8'hff, 8'h34, 8'h56, 8'h00};
        commit_buffer();
        buf_bytes = {8'h00, 8'h01};
        commit_buffer();
        wait_drained();

        // one-byte lengths: good unit then truncated, then zero length
        write_config(1'b1, 3'd1);
        buf_bytes = {8'h02, 8'h41, 8'hff, 8'h05, 8'h65, 8'h00};
        commit_buffer();
        buf_bytes = {8'h00, 8'h11, 8'h22, 8'h33};
        commit_buffer();
        wait_drained();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            if (p < 3)
            begin
                send_idle_pct = 34;
                recv_idle_pct = 55;
            end
            else if (p < 6)
            begin
                send_idle_pct = 55;
                recv_idle_pct = 34;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_config(PHASE_MODE[p], PHASE_LEN_BYTES[p]);
            while (stream_q.size() < PHASE_BYTES)
            begin
                if (cfg_len_mode)
                    add_length_buffer();
                else
                    add_start_code_buffer();
            end
            wait_drained();
        end

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
